### design/bfpe_pkg.sv
// bfpe_pkg: shared constants, codes, command/status structs and the instruction
// decoder for the tape-language program executor
// no dependencies
`timescale 1ns / 1ps

package bfpe_pkg;

  localparam int PROG_DEPTH  = 65536;
  localparam int CELL_DEPTH  = 32768;
  localparam int STEP_BUDGET = 1048576;

  localparam int PROG_AW = $clog2(PROG_DEPTH);
  localparam int CELL_AW = $clog2(CELL_DEPTH);
  localparam int PC_W    = PROG_AW + 1;
  localparam int DEPTH_W = 17;
  localparam int STEP_W  = $clog2(STEP_BUDGET);

  // request opcodes
  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_RUN    = 2'd1;
  localparam logic [1:0] OP_SUPPLY = 2'd2;

  // result kinds
  localparam logic [2:0] KIND_LOADED  = 3'd0;
  localparam logic [2:0] KIND_OUTPUT  = 3'd1;
  localparam logic [2:0] KIND_INPUT   = 3'd2;
  localparam logic [2:0] KIND_HALT    = 3'd3;
  localparam logic [2:0] KIND_BRACKET = 3'd4;

  // program characters
  localparam logic [7:0] CH_INC   = 8'h2B;
  localparam logic [7:0] CH_DEC   = 8'h2D;
  localparam logic [7:0] CH_RIGHT = 8'h3E;
  localparam logic [7:0] CH_LEFT  = 8'h3C;
  localparam logic [7:0] CH_OPEN  = 8'h5B;
  localparam logic [7:0] CH_CLOSE = 8'h5D;
  localparam logic [7:0] CH_OUT   = 8'h2E;
  localparam logic [7:0] CH_IN    = 8'h2C;
  localparam logic [7:0] CH_END   = 8'h00;

  typedef enum logic [3:0] {
    I_HALT, I_INC, I_DEC, I_RIGHT, I_LEFT, I_OUT, I_IN, I_OPEN, I_CLOSE, I_NOP
  } instr_t;

  typedef struct packed {
    logic       prog_wr;
    logic       load_restart;
    logic       clear_step;
    logic       supply;
    logic       pc_inc;
    logic       pc_dec;
    logic       cell_inc;
    logic       cell_dec;
    logic       ptr_inc;
    logic       ptr_dec;
    logic       set_await;
    logic       set_stop;
    logic       depth_one;
    logic       depth_inc;
    logic       depth_dec;
    logic       depth_clr;
    logic       step_clr;
    logic       step_inc;
    logic       emit;
    logic [2:0] kind;
  } ctrl_cmd_t;

  typedef struct packed {
    instr_t instr;
    logic   pc_at_end;
    logic   pc_zero;
    logic   cell_zero;
    logic   depth_one;
    logic   budget_last;
    logic   clear_last;
    logic   stopped;
    logic   awaiting;
  } dp_status_t;

  function automatic instr_t decode_instr(input logic [7:0] b);
    instr_t r;
    r = I_NOP;
    if (b == CH_END)   r = I_HALT;
    if (b == CH_INC)   r = I_INC;
    if (b == CH_DEC)   r = I_DEC;
    if (b == CH_RIGHT) r = I_RIGHT;
    if (b == CH_LEFT)  r = I_LEFT;
    if (b == CH_OUT)   r = I_OUT;
    if (b == CH_IN)    r = I_IN;
    if (b == CH_OPEN)  r = I_OPEN;
    if (b == CH_CLOSE) r = I_CLOSE;
    return r;
  endfunction

endpackage

### design/bfpe_dpath.sv
// bfpe_dpath: program and cell memories, machine registers and result register
// depends on bfpe_pkg
`timescale 1ns / 1ps

module bfpe_dpath (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [15:0]           in_prog_addr,
  input  logic [7:0]            in_data_byte,
  input  bfpe_pkg::ctrl_cmd_t   cmd,
  output bfpe_pkg::dp_status_t  status,
  output logic                  out_valid,
  output logic [2:0]            out_kind,
  output logic [7:0]            out_byte
);

  logic [7:0] prog_mem [bfpe_pkg::PROG_DEPTH];
  logic [7:0] cell_mem [bfpe_pkg::CELL_DEPTH];
  logic [7:0] prog_q;
  logic [7:0] cell_q;

  logic [bfpe_pkg::PC_W-1:0]    pc_r, pc_nxt;
  logic [bfpe_pkg::PC_W-1:0]    len_r, len_nxt;
  logic [bfpe_pkg::CELL_AW-1:0] ptr_r, ptr_nxt;
  logic [bfpe_pkg::CELL_AW-1:0] clr_r, clr_nxt;
  logic [bfpe_pkg::DEPTH_W-1:0] depth_r, depth_nxt;
  logic [bfpe_pkg::STEP_W-1:0]  step_r, step_nxt;
  logic                         await_r, await_nxt;
  logic                         stop_r, stop_nxt;
  logic                         valid_r;
  logic [2:0]                   kind_r;
  logic [7:0]                   byte_r;

  logic                         prog_we;
  logic [bfpe_pkg::PC_W-1:0]    addr_ext;
  logic [bfpe_pkg::PC_W-1:0]    addr_len;
  logic                         cell_we;
  logic [bfpe_pkg::CELL_AW-1:0] cell_wa;
  logic [7:0]                   cell_wd;

  assign addr_ext = bfpe_pkg::PC_W'(in_prog_addr);
  assign addr_len = addr_ext + bfpe_pkg::PC_W'(1);
  assign prog_we  = cmd.prog_wr && (addr_ext < bfpe_pkg::PC_W'(bfpe_pkg::PROG_DEPTH));

  always_comb begin
    pc_nxt    = pc_r;
    len_nxt   = len_r;
    ptr_nxt   = ptr_r;
    clr_nxt   = clr_r;
    depth_nxt = depth_r;
    step_nxt  = step_r;
    await_nxt = await_r;
    stop_nxt  = stop_r;
    if (cmd.pc_inc) pc_nxt = pc_r + bfpe_pkg::PC_W'(1);
    if (cmd.pc_dec) pc_nxt = pc_r - bfpe_pkg::PC_W'(1);
    if (cmd.ptr_inc) begin
      ptr_nxt = (ptr_r == bfpe_pkg::CELL_AW'(bfpe_pkg::CELL_DEPTH - 1)) ? '0
              : ptr_r + bfpe_pkg::CELL_AW'(1);
    end
    if (cmd.ptr_dec) begin
      ptr_nxt = (ptr_r == '0) ? bfpe_pkg::CELL_AW'(bfpe_pkg::CELL_DEPTH - 1)
              : ptr_r - bfpe_pkg::CELL_AW'(1);
    end
    if (cmd.depth_one) depth_nxt = bfpe_pkg::DEPTH_W'(1);
    if (cmd.depth_inc) depth_nxt = depth_r + bfpe_pkg::DEPTH_W'(1);
    if (cmd.depth_dec) depth_nxt = depth_r - bfpe_pkg::DEPTH_W'(1);
    if (cmd.depth_clr) depth_nxt = '0;
    if (cmd.step_clr) step_nxt = '0;
    if (cmd.step_inc) step_nxt = step_r + bfpe_pkg::STEP_W'(1);
    if (cmd.supply) await_nxt = 1'b0;
    if (cmd.set_await) await_nxt = 1'b1;
    if (cmd.set_stop) stop_nxt = 1'b1;
    if (cmd.clear_step) clr_nxt = clr_r + bfpe_pkg::CELL_AW'(1);
    if (cmd.load_restart) begin
      len_nxt   = (addr_len > bfpe_pkg::PC_W'(bfpe_pkg::PROG_DEPTH))
                ? bfpe_pkg::PC_W'(bfpe_pkg::PROG_DEPTH) : addr_len;
      pc_nxt    = '0;
      ptr_nxt   = '0;
      clr_nxt   = '0;
      depth_nxt = '0;
      await_nxt = 1'b0;
      stop_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r    <= '0;
      len_r   <= '0;
      ptr_r   <= '0;
      clr_r   <= '0;
      depth_r <= '0;
      step_r  <= '0;
      await_r <= 1'b0;
      stop_r  <= 1'b1;
      valid_r <= 1'b0;
    end else begin
      pc_r    <= pc_nxt;
      len_r   <= len_nxt;
      ptr_r   <= ptr_nxt;
      clr_r   <= clr_nxt;
      depth_r <= depth_nxt;
      step_r  <= step_nxt;
      await_r <= await_nxt;
      stop_r  <= stop_nxt;
      valid_r <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      kind_r <= cmd.kind;
      byte_r <= (cmd.kind == bfpe_pkg::KIND_OUTPUT) ? cell_q : 8'd0;
    end
  end

  // program store: read address follows the next pc so the registered data matches the current pc
  always_ff @(posedge clk) begin
    if (prog_we) prog_mem[in_prog_addr[bfpe_pkg::PROG_AW-1:0]] <= in_data_byte;
    prog_q <= prog_mem[pc_nxt[bfpe_pkg::PROG_AW-1:0]];
  end

  always_comb begin
    cell_we = 1'b0;
    cell_wa = ptr_r;
    cell_wd = cell_q;
    priority if (cmd.clear_step) begin
      cell_we = 1'b1;
      cell_wa = clr_r;
      cell_wd = 8'd0;
    end else if (cmd.supply) begin
      cell_we = 1'b1;
      cell_wd = in_data_byte;
    end else if (cmd.cell_inc) begin
      cell_we = 1'b1;
      cell_wd = cell_q + 8'd1;
    end else if (cmd.cell_dec) begin
      cell_we = 1'b1;
      cell_wd = cell_q - 8'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cell_we) cell_mem[cell_wa] <= cell_wd;
    cell_q <= cell_mem[ptr_r];
  end

  assign status.instr       = bfpe_pkg::decode_instr(prog_q);
  assign status.pc_at_end   = (pc_r >= len_r);
  assign status.pc_zero     = (pc_r == '0);
  assign status.cell_zero   = (cell_q == 8'd0);
  assign status.depth_one   = (depth_r == bfpe_pkg::DEPTH_W'(1));
  assign status.budget_last = (step_r == bfpe_pkg::STEP_W'(bfpe_pkg::STEP_BUDGET - 1));
  assign status.clear_last  = (clr_r == bfpe_pkg::CELL_AW'(bfpe_pkg::CELL_DEPTH - 1));
  assign status.stopped     = stop_r;
  assign status.awaiting    = await_r;

  assign out_valid = valid_r;
  assign out_kind  = kind_r;
  assign out_byte  = byte_r;

endmodule

### design/bfpe_ctrl.sv
// bfpe_ctrl: sequencer for request handling, instruction execution and bracket scans
// depends on bfpe_pkg
`timescale 1ns / 1ps

module bfpe_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  accept,
  input  logic [1:0]            in_op,
  input  logic                  in_load_last,
  input  bfpe_pkg::dp_status_t  status,
  output bfpe_pkg::ctrl_cmd_t   cmd,
  output logic                  busy
);

  typedef enum logic [7:0] {
    S_IDLE      = 8'b0000_0001,
    S_CLEAR     = 8'b0000_0010,
    S_FETCH     = 8'b0000_0100,
    S_EXEC      = 8'b0000_1000,
    S_FWD_ADDR  = 8'b0001_0000,
    S_FWD_DATA  = 8'b0010_0000,
    S_BACK_ADDR = 8'b0100_0000,
    S_BACK_DATA = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic   adv;
  logic   fail;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    adv       = 1'b0;
    fail      = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_op == bfpe_pkg::OP_LOAD) begin
            cmd.prog_wr = 1'b1;
            cmd.emit    = 1'b1;
            cmd.kind    = bfpe_pkg::KIND_LOADED;
            if (in_load_last) begin
              cmd.load_restart = 1'b1;
              state_nxt        = S_CLEAR;
            end
          end else if (in_op == bfpe_pkg::OP_RUN || in_op == bfpe_pkg::OP_SUPPLY) begin
            cmd.step_clr = 1'b1;
            if (status.stopped) begin
              cmd.emit = 1'b1;
              cmd.kind = bfpe_pkg::KIND_HALT;
            end else if (status.awaiting) begin
              if (in_op == bfpe_pkg::OP_SUPPLY) begin
                cmd.supply = 1'b1;
                cmd.pc_inc = 1'b1;
                state_nxt  = S_FETCH;
              end else begin
                cmd.emit = 1'b1;
                cmd.kind = bfpe_pkg::KIND_INPUT;
              end
            end else begin
              state_nxt = S_FETCH;
            end
          end else begin
            cmd.emit = 1'b1;
            cmd.kind = bfpe_pkg::KIND_LOADED;
          end
        end
      end
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (status.clear_last) state_nxt = S_IDLE;
      end
      S_FETCH: begin
        if (status.pc_at_end) begin
          cmd.set_stop = 1'b1;
          cmd.emit     = 1'b1;
          cmd.kind     = bfpe_pkg::KIND_HALT;
          state_nxt    = S_IDLE;
        end else begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (status.instr)
          bfpe_pkg::I_HALT: begin
            cmd.set_stop = 1'b1;
            cmd.emit     = 1'b1;
            cmd.kind     = bfpe_pkg::KIND_HALT;
            state_nxt    = S_IDLE;
          end
          bfpe_pkg::I_INC: begin
            cmd.cell_inc = 1'b1;
            adv          = 1'b1;
          end
          bfpe_pkg::I_DEC: begin
            cmd.cell_dec = 1'b1;
            adv          = 1'b1;
          end
          bfpe_pkg::I_RIGHT: begin
            cmd.ptr_inc = 1'b1;
            adv         = 1'b1;
          end
          bfpe_pkg::I_LEFT: begin
            cmd.ptr_dec = 1'b1;
            adv         = 1'b1;
          end
          bfpe_pkg::I_OUT: begin
            cmd.pc_inc = 1'b1;
            cmd.emit   = 1'b1;
            cmd.kind   = bfpe_pkg::KIND_OUTPUT;
            state_nxt  = S_IDLE;
          end
          bfpe_pkg::I_IN: begin
            cmd.set_await = 1'b1;
            cmd.emit      = 1'b1;
            cmd.kind      = bfpe_pkg::KIND_INPUT;
            state_nxt     = S_IDLE;
          end
          bfpe_pkg::I_OPEN: begin
            if (status.cell_zero) begin
              cmd.depth_one = 1'b1;
              state_nxt     = S_FWD_ADDR;
            end else begin
              adv = 1'b1;
            end
          end
          bfpe_pkg::I_CLOSE: begin
            if (!status.cell_zero) begin
              cmd.depth_one = 1'b1;
              state_nxt     = S_BACK_ADDR;
            end else begin
              adv = 1'b1;
            end
          end
          default: begin
            adv = 1'b1;
          end
        endcase
      end
      S_FWD_ADDR: begin
        cmd.pc_inc = 1'b1;
        state_nxt  = S_FWD_DATA;
      end
      S_FWD_DATA: begin
        // pc already advanced: program end or a zero byte ends the scan
        if (status.pc_at_end || status.instr == bfpe_pkg::I_HALT) begin
          fail = 1'b1;
        end else if (status.instr == bfpe_pkg::I_OPEN) begin
          cmd.depth_inc = 1'b1;
          state_nxt     = S_FWD_ADDR;
        end else if (status.instr == bfpe_pkg::I_CLOSE) begin
          cmd.depth_dec = 1'b1;
          if (status.depth_one) adv = 1'b1;
          else state_nxt = S_FWD_ADDR;
        end else begin
          state_nxt = S_FWD_ADDR;
        end
      end
      S_BACK_ADDR: begin
        if (status.pc_zero) begin
          fail = 1'b1;
        end else begin
          cmd.pc_dec = 1'b1;
          state_nxt  = S_BACK_DATA;
        end
      end
      S_BACK_DATA: begin
        if (status.instr == bfpe_pkg::I_CLOSE) begin
          cmd.depth_inc = 1'b1;
          state_nxt     = S_BACK_ADDR;
        end else if (status.instr == bfpe_pkg::I_OPEN) begin
          cmd.depth_dec = 1'b1;
          if (status.depth_one) adv = 1'b1;
          else state_nxt = S_BACK_ADDR;
        end else begin
          state_nxt = S_BACK_ADDR;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (fail) begin
      cmd.depth_clr = 1'b1;
      cmd.set_stop  = 1'b1;
      cmd.emit      = 1'b1;
      cmd.kind      = bfpe_pkg::KIND_BRACKET;
      state_nxt     = S_IDLE;
    end

    // finish the instruction; an exhausted step budget ends the request silently
    if (adv) begin
      cmd.pc_inc = 1'b1;
      if (status.budget_last) begin
        state_nxt = S_IDLE;
      end else begin
        cmd.step_inc = 1'b1;
        state_nxt    = S_FETCH;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

### design/bf_program_executor_top.sv
// bf_program_executor_top: tape-language program executor, top level
// depends on bfpe_pkg, bfpe_ctrl, bfpe_dpath
`timescale 1ns / 1ps

// A request is taken when start is high and busy is low. Load requests return
// their result (kind 0) in the next cycle; a load marked last then holds busy for
// a cell store clearing pass over all 32768 cells. Run and supply requests step
// through each instruction in a FETCH state (program and cell memory read), then
// an EXEC state, plus an address and a data state per byte passed in a bracket
// scan; a request ends at an output byte, an input request, a halt or an unmatched
// bracket, and its result is on the outputs in the first cycle with busy low.
// A request that reaches 1048576 instructions ends with no result and keeps all
// state for the next run. Results show on out_valid for exactly one cycle and
// cannot be held off by the receiver.

module bf_program_executor_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_op,
  input  logic [15:0] in_prog_addr,
  input  logic [7:0]  in_data_byte,
  input  logic        in_load_last,
  output logic        out_valid,
  output logic [2:0]  out_kind,
  output logic [7:0]  out_byte
);

  bfpe_pkg::ctrl_cmd_t  cmd;
  bfpe_pkg::dp_status_t status;
  logic                 accept;

  assign accept = start && !busy;

  bfpe_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .in_op        (in_op),
    .in_load_last (in_load_last),
    .status       (status),
    .cmd          (cmd),
    .busy         (busy)
  );

  bfpe_dpath u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_prog_addr (in_prog_addr),
    .in_data_byte (in_data_byte),
    .cmd          (cmd),
    .status       (status),
    .out_valid    (out_valid),
    .out_kind     (out_kind),
    .out_byte     (out_byte)
  );

  // every accepted request either gives a result next cycle or keeps the block busy
  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (busy || out_valid))
    else $error("accepted request neither busy nor answered");

  // only a load result may overlap the clearing pass
  a_result_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind != bfpe_pkg::KIND_LOADED) |-> !busy)
    else $error("run result while still busy");

  a_byte_only_on_output: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind != bfpe_pkg::KIND_OUTPUT) |-> (out_byte == 8'd0))
    else $error("nonzero byte on non-output result");

  a_clear_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clear_step |-> !(cmd.supply || cmd.cell_inc || cmd.cell_dec || cmd.emit))
    else $error("cell write during clearing pass");

endmodule

### sim/tb_top.sv
// tb_top: self-checking testbench for bf_program_executor_top, the tape-language
// program executor; predicts every result from a shadow interpreter of its own
// depends on bfpe_pkg and the design sources under design/
`timescale 1ns / 1ps

module tb_top;
  import bfpe_pkg::*;

  localparam int     HALF_PERIOD = 4;
  localparam longint TIMEOUT_NS  = 64'd250_000_000;
  localparam logic [1:0] OP_SPARE = 2'd3;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] value;
  } exec_result_t;

  typedef enum int {FLAW_NONE, FLAW_OPEN, FLAW_CLOSE, FLAW_ZERO, FLAW_CUT} flaw_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [1:0]  in_op;
  logic [15:0] in_prog_addr;
  logic [7:0]  in_data_byte;
  logic        in_load_last;
  logic        out_valid;
  logic [2:0]  out_kind;
  logic [7:0]  out_byte;

  bf_program_executor_top dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_op        (in_op),
    .in_prog_addr (in_prog_addr),
    .in_data_byte (in_data_byte),
    .in_load_last (in_load_last),
    .out_valid    (out_valid),
    .out_kind     (out_kind),
    .out_byte     (out_byte)
  );

  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  // shadow interpreter state
  logic [7:0]         shadow_prog [PROG_DEPTH];
  logic [7:0]         shadow_tape [CELL_DEPTH];
  logic [PC_W-1:0]    shadow_pc  = '0;
  logic [PC_W-1:0]    shadow_len = '0;
  logic [CELL_AW-1:0] shadow_ptr = '0;
  logic [DEPTH_W-1:0] scan_depth = '0;
  bit                 wants_input = 1'b0;
  bit                 is_halted   = 1'b1;

  exec_result_t pending_events [$];
  logic [7:0]   prog_text [$];
  int           error_count = 0;
  int           idle_pct    = 7;

  function automatic logic [7:0] fetch_prog(input logic [PC_W-1:0] a);
    if (a >= PROG_DEPTH) return 8'h00;
    return shadow_prog[a[PROG_AW-1:0]];
  endfunction

  function automatic void bracket_fault(output exec_result_t res);
    scan_depth = '0;
    is_halted  = 1'b1;
    res = '{kind: KIND_BRACKET, value: 8'h00};
  endfunction

  // executes until an event; returns 0 when the step budget runs out
  function automatic bit interp_run(output exec_result_t res);
    logic [7:0] op_byte;
    logic [7:0] scan_byte;
    res = '{kind: KIND_HALT, value: 8'h00};
    if (is_halted) return 1'b1;
    if (wants_input) begin
      res.kind = KIND_INPUT;
      return 1'b1;
    end
    for (int unsigned n = 0; n < STEP_BUDGET; n++) begin
      op_byte = fetch_prog(shadow_pc);
      if (shadow_pc >= shadow_len || op_byte == CH_END) begin
        is_halted = 1'b1;
        res.kind  = KIND_HALT;
        return 1'b1;
      end
      case (op_byte)
        CH_INC:   shadow_tape[shadow_ptr] = shadow_tape[shadow_ptr] + 8'd1;
        CH_DEC:   shadow_tape[shadow_ptr] = shadow_tape[shadow_ptr] - 8'd1;
        CH_RIGHT: shadow_ptr = (shadow_ptr == CELL_DEPTH - 1) ? '0 : shadow_ptr + 1'b1;
        CH_LEFT:  shadow_ptr = (shadow_ptr == 0) ? CELL_AW'(CELL_DEPTH - 1) : shadow_ptr - 1'b1;
        CH_OUT: begin
          shadow_pc = shadow_pc + 1'b1;
          res.kind  = KIND_OUTPUT;
          res.value = shadow_tape[shadow_ptr];
          return 1'b1;
        end
        CH_IN: begin
          wants_input = 1'b1;
          res.kind    = KIND_INPUT;
          return 1'b1;
        end
        CH_OPEN: begin
          if (shadow_tape[shadow_ptr] == 8'd0) begin
            scan_depth = DEPTH_W'(1);
            while (scan_depth != 0) begin
              shadow_pc = shadow_pc + 1'b1;
              if (shadow_pc >= shadow_len) begin
                bracket_fault(res);
                return 1'b1;
              end
              scan_byte = fetch_prog(shadow_pc);
              if (scan_byte == CH_END) begin
                bracket_fault(res);
                return 1'b1;
              end
              if (scan_byte == CH_OPEN) scan_depth = scan_depth + 1'b1;
              else if (scan_byte == CH_CLOSE) scan_depth = scan_depth - 1'b1;
            end
          end
        end
        CH_CLOSE: begin
          if (shadow_tape[shadow_ptr] != 8'd0) begin
            scan_depth = DEPTH_W'(1);
            while (scan_depth != 0) begin
              if (shadow_pc == 0) begin
                bracket_fault(res);
                return 1'b1;
              end
              shadow_pc = shadow_pc - 1'b1;
              scan_byte = fetch_prog(shadow_pc);
              if (scan_byte == CH_CLOSE) scan_depth = scan_depth + 1'b1;
              else if (scan_byte == CH_OPEN) scan_depth = scan_depth - 1'b1;
            end
          end
        end
        default: ;
      endcase
      shadow_pc = shadow_pc + 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic bit interp_request(input logic [1:0] op, input logic [15:0] addr,
                                        input logic [7:0] data, input logic last,
                                        output exec_result_t res);
    res = '{kind: KIND_LOADED, value: 8'h00};
    case (op)
      OP_LOAD: begin
        // a 16-bit address always lies inside the program store
        shadow_prog[addr] = data;
        if (last) begin
          shadow_len  = {1'b0, addr} + 1'b1;
          shadow_pc   = '0;
          shadow_ptr  = '0;
          scan_depth  = '0;
          wants_input = 1'b0;
          is_halted   = 1'b0;
          foreach (shadow_tape[i]) shadow_tape[i] = 8'h00;
        end
        return 1'b1;
      end
      OP_RUN: return interp_run(res);
      OP_SUPPLY: begin
        // a byte supplied with no input wanted is dropped
        if (!is_halted && wants_input) begin
          shadow_tape[shadow_ptr] = data;
          wants_input = 1'b0;
          shadow_pc   = shadow_pc + 1'b1;
        end
        return interp_run(res);
      end
      default: return 1'b1;
    endcase
  endfunction

  task automatic report_mismatch(input string what);
    if (error_count < 40) $display("MISMATCH @%0t: %s", $time, what);
    error_count++;
  endtask

  always @(posedge clk) begin : check_events
    exec_result_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1) begin
      if (pending_events.size() == 0) begin
        report_mismatch($sformatf("unexpected result kind %0d byte %02h", out_kind, out_byte));
      end else begin
        want = pending_events.pop_front();
        if (out_kind !== want.kind)
          report_mismatch($sformatf("kind %0d, wanted %0d", out_kind, want.kind));
        if (out_byte !== want.value)
          report_mismatch($sformatf("byte %02h, wanted %02h (kind %0d)",
                                    out_byte, want.value, want.kind));
      end
    end
  end

  task automatic send_request(input logic [1:0] op, input logic [15:0] addr,
                              input logic [7:0] data, input logic last);
    exec_result_t res;
    @(negedge clk);
    start        <= 1'b1;
    in_op        <= op;
    in_prog_addr <= addr;
    in_data_byte <= data;
    in_load_last <= last;
    do @(posedge clk); while (busy !== 1'b0);
    if (interp_request(op, addr, data, last, res)) pending_events.push_back(res);
    if ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      start <= 1'b0;
      repeat ($urandom_range(30)) @(negedge clk);
    end
  endtask

  // unused fields carry random values
  task automatic send_op(input logic [1:0] op);
    send_request(op, 16'($urandom), 8'($urandom), 1'($urandom));
  endtask

  task automatic wait_drained();
    @(negedge clk);
    start <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
  endtask

  function automatic void add_text(input string s);
    foreach (s[i]) prog_text.push_back(s[i]);
  endfunction

  function automatic logic [7:0] noise_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(1, 255));
    while (b == CH_INC || b == CH_DEC || b == CH_RIGHT || b == CH_LEFT || b == CH_OPEN ||
           b == CH_CLOSE || b == CH_OUT || b == CH_IN);
    return b;
  endfunction

  // loads prog_text in shuffled order; the final byte goes last
  task automatic load_program();
    int order [$];
    int n, j, tmp;
    n = prog_text.size();
    for (int i = 0; i < n - 1; i++) order.push_back(i);
    for (int i = n - 2; i > 0; i--) begin
      j = $urandom_range(i);
      tmp = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    foreach (order[k]) send_request(OP_LOAD, 16'(order[k]), prog_text[order[k]], 1'b0);
    send_request(OP_LOAD, 16'(n - 1), prog_text[n - 1], 1'b1);
  endtask

  // well-formed segments; a flawed program gets one kind of defect only, so that
  // stray brackets can never pair up into a runaway loop
  function automatic void compose_program();
    flaw_t flaw;
    int nseg;
    prog_text.delete();
    flaw = ($urandom_range(3) == 0) ? flaw_t'($urandom_range(1, 4)) : FLAW_NONE;
    nseg = $urandom_range(6, 16);
    for (int s = 0; s < nseg; s++) begin
      if (flaw != FLAW_NONE && flaw != FLAW_CUT && $urandom_range(3) == 0) begin
        case (flaw)
          FLAW_OPEN:  prog_text.push_back(CH_OPEN);
          FLAW_CLOSE: prog_text.push_back(CH_CLOSE);
          default:    prog_text.push_back(CH_END);
        endcase
      end
      case ($urandom_range(9))
        0, 1: repeat ($urandom_range(1, 6)) prog_text.push_back($urandom_range(1) ? CH_INC : CH_DEC);
        2: repeat ($urandom_range(1, 4)) prog_text.push_back($urandom_range(1) ? CH_RIGHT : CH_LEFT);
        3, 4: prog_text.push_back(CH_OUT);
        5: prog_text.push_back(CH_IN);
        6: prog_text.push_back(noise_byte());
        7: add_text($urandom_range(1) ? "[-]" : "[+]");
        8: begin
          // counted loop: counter one cell right, body works on the cell left of it
          add_text(">[-]");
          repeat ($urandom_range(1, 5)) prog_text.push_back(CH_INC);
          add_text("[<");
          repeat ($urandom_range(1, 4)) begin
            case ($urandom_range(5))
              0: prog_text.push_back(CH_INC);
              1: prog_text.push_back(CH_DEC);
              2, 3: prog_text.push_back(CH_OUT);
              4: prog_text.push_back(CH_IN);
              default: add_text("[-]");
            endcase
          end
          add_text(">-]<");
        end
        default: add_text($urandom_range(1) ? "[->+<]" : "[-<+>]");
      endcase
    end
    if (flaw == FLAW_CUT) repeat ($urandom_range(1, prog_text.size() - 1)) void'(prog_text.pop_back());
  endfunction

  // runs the loaded program until it halts or 400 requests are used; counts the run and supply requests
  task automatic drive_program(output int runs);
    int pick, guard;
    runs = 0;
    guard = 0;
    while (!is_halted && guard < 400) begin
      guard++;
      pick = $urandom_range(99);
      if (pick < 4) begin
        send_op(OP_SPARE);
      end else if (pick < 8) begin
        // stray write above the program, never marked last
        send_request(OP_LOAD, 16'($urandom_range(int'(shadow_len), 65535)), 8'($urandom), 1'b0);
      end else begin
        if (wants_input) send_op(pick < 85 ? OP_SUPPLY : OP_RUN);
        else send_op(pick < 90 ? OP_RUN : OP_SUPPLY);
        runs++;
      end
    end
    if ($urandom_range(1)) begin
      send_op($urandom_range(1) ? OP_RUN : OP_SUPPLY);
      runs++;
    end
  endtask

  task automatic random_phase(input int gap_pct, input int quota);
    int done_items, runs;
    done_items = 0;
    idle_pct = gap_pct;
    while (done_items < quota) begin
      if ($urandom_range(2) == 0) wait_drained();
      compose_program();
      load_program();
      done_items += prog_text.size();
      drive_program(runs);
      done_items += runs;
    end
  endtask

  task automatic test_reset_state();
    send_op(OP_RUN);
    send_op(OP_SPARE);
    send_request(OP_SUPPLY, 16'h0000, 8'h00, 1'b1);
    send_request(OP_LOAD, 16'hFFFF, 8'hFF, 1'b0);
  endtask

  // cell wrap on decrement, pointer wrap both ways, input request and halt on zero byte
  task automatic test_wrap_and_input();
    wait_drained();
    prog_text.delete();
    add_text("-<+>.<.,.");
    prog_text.push_back(CH_END);
    add_text("+");
    load_program();
    send_op(OP_RUN);
    send_op(OP_RUN);
    send_op(OP_RUN);
    send_op(OP_RUN);
    send_request(OP_SUPPLY, 16'h5A5A, 8'hFF, 1'b0);
    send_op(OP_RUN);
    send_request(OP_SUPPLY, 16'hA5A5, 8'h00, 1'b1);
  endtask

  task automatic test_bracket_faults();
    // close on zero cell falls through, the later one scans back to address zero unmatched
    prog_text.delete();
    add_text("]+[-]+]");
    load_program();
    send_op(OP_RUN);
    send_op(OP_RUN);
    // open scan meets a zero byte
    prog_text.delete();
    add_text("[.");
    prog_text.push_back(CH_END);
    add_text("]");
    load_program();
    send_op(OP_RUN);
    // open scan meets the program end
    prog_text.delete();
    add_text("[");
    load_program();
    send_op(OP_RUN);
  endtask

  // endless loop exhausts the step budget; patching the loop lets a later run resume
  task automatic test_step_budget();
    wait_drained();
    prog_text.delete();
    add_text("+[]");
    load_program();
    send_op(OP_RUN);
    send_request(OP_LOAD, 16'd2, CH_OUT, 1'b0);
    send_op(OP_RUN);
    send_op(OP_RUN);
    wait_drained();
  endtask

  task automatic test_sparse_gaps();
    random_phase(7, 570);
  endtask

  task automatic test_dense_gaps();
    random_phase(80, 570);
  endtask

  task automatic test_no_gaps();
    random_phase(0, 570);
  endtask

  initial begin
    rst_n        = 1'b0;
    start        = 1'b0;
    in_op        = OP_LOAD;
    in_prog_addr = '0;
    in_data_byte = '0;
    in_load_last = 1'b0;
    foreach (shadow_tape[i]) shadow_tape[i] = 8'h00;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    idle_pct = 7;
    test_reset_state();
    test_wrap_and_input();
    test_bracket_faults();
    test_step_budget();
    test_sparse_gaps();
    test_dense_gaps();
    test_no_gaps();

    wait_drained();
    repeat (200) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("timeout with %0d results outstanding", pending_events.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

### files.f
design/bfpe_pkg.sv
design/bfpe_dpath.sv
design/bfpe_ctrl.sv
design/bf_program_executor_top.sv
sim/tb_top.sv
